// File: rtl/csst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csst_pkg;

   // default sizes
   localparam int CSST_MAX_SEGMENTS = 64;
   localparam int CSST_COORD_BITS   = 16;

   // pixel output width and quotient bits of the rounding divider
   localparam int PIX_BITS  = 12;
   localparam int QUOT_BITS = 12;

   // curve kind codes
   localparam logic [1:0] KIND_BEZIER  = 2'd0;
   localparam logic [1:0] KIND_BSPLINE = 2'd1;
   localparam logic [1:0] KIND_CATMULL = 2'd2;

   // register reset values
   localparam logic [1:0] KIND_RESET = KIND_BEZIER;
   localparam logic [6:0] SEG_RESET  = 7'd50;

   // register index codes (address bit 2)
   localparam logic REG_CURVE_KIND = 1'b0;
   localparam logic REG_SEGMENTS   = 1'b1;

   // pixel saturation bounds
   localparam logic [PIX_BITS-1:0] PIX_MAX = 12'h7FF;
   localparam logic [PIX_BITS-1:0] PIX_MIN = 12'h800;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_HORNER,
      ST_DIV_INIT,
      ST_DIV,
      ST_EMIT,
      ST_ERROR
   } csst_state_type;

   typedef struct packed {
      logic       capture;
      logic       scale;
      logic       horner;
      logic [1:0] step;
      logic       div_init;
      logic       div_step;
      logic       keep_prev;
      logic       emit;
      logic       emit_error;
      logic       last_of_span;
      logic       knot_mark;
      logic [1:0] kind;
   } csst_cmd_type;

   typedef struct packed {
      logic out_free;
   } csst_sts_type;

   // 16 times the curve denominator
   function automatic logic [6:0] den_base(input logic [1:0] kind);
      logic [6:0] r;
      unique case (kind)
         KIND_BEZIER:  r = 7'd16;
         KIND_BSPLINE: r = 7'd96;
         default:      r = 7'd32;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/csst_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module csst_lane import csst_pkg::*; #(
   parameter int COORD_BITS = CSST_COORD_BITS,
   parameter int SEG_BITS   = 7
) (
   input  wire logic                         clock,
   input  wire csst_cmd_type                 cmd,
   input  wire logic signed [COORD_BITS-1:0] pa,
   input  wire logic signed [COORD_BITS-1:0] pb,
   input  wire logic signed [COORD_BITS-1:0] pc,
   input  wire logic signed [COORD_BITS-1:0] pd,
   input  wire logic [SEG_BITS-1:0]          n,
   input  wire logic [SEG_BITS-1:0]          i,
   input  wire logic [3*SEG_BITS+6:0]        den,
   output logic [PIX_BITS-1:0]               pix
);

   localparam int CW = COORD_BITS + 4;
   localparam int NW = CW + 3 * SEG_BITS + 2;
   localparam int DW = 3 * SEG_BITS + 7;
   localparam int RW = (NW + 2 > DW + QUOT_BITS) ? NW + 2 : DW + QUOT_BITS;

   logic signed [CW-1:0] ea, eb, ec, ed;
   logic signed [CW-1:0] c0, c1, c2, c3;
   logic signed [NW-1:0] k0_ff, t1_ff, t2_ff, t3_ff, acc_ff;
   logic signed [NW-1:0] k0_in, t1_in, t2_in, t3_in, acc_in;
   logic signed [NW-1:0] src, term;
   logic signed [SEG_BITS:0] n_s, i_s;
   logic [NW-1:0]        mag;
   logic [RW-1:0]        rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUOT_BITS-1:0] q_ff, q_in;
   logic                 neg_ff, neg_in;
   logic [PIX_BITS-1:0]  mag12;

   // cubic coefficients of the window
   always_comb begin
      ea = CW'(pa);
      eb = CW'(pb);
      ec = CW'(pc);
      ed = CW'(pd);
      c0 = -ea + eb + eb + eb - ec - ec - ec + ed;
      unique case (cmd.kind)
         KIND_BEZIER: begin
            c1 = ea + ea + ea - (eb <<< 2) - eb - eb + ec + ec + ec;
            c2 = -ea - ea - ea + eb + eb + eb;
            c3 = ea;
         end
         KIND_BSPLINE: begin
            c1 = ea + ea + ea - (eb <<< 2) - eb - eb + ec + ec + ec;
            c2 = -ea - ea - ea + ec + ec + ec;
            c3 = ea + (eb <<< 2) + ec;
         end
         default: begin
            c1 = ea + ea - (eb <<< 2) - eb + (ec <<< 2) - ed;
            c2 = -ea + ec;
            c3 = eb + eb;
         end
      endcase
   end

   // coefficient scaling, horner step and divider
   always_comb begin
      n_s    = {1'b0, n};
      i_s    = {1'b0, i};
      k0_in  = k0_ff;
      t1_in  = t1_ff;
      t2_in  = t2_ff;
      t3_in  = t3_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      neg_in = neg_ff;
      src    = (cmd.step == 2'd0) ? k0_ff : acc_ff;
      unique case (cmd.step)
         2'd0:    term = t1_ff;
         2'd1:    term = t2_ff;
         default: term = t3_ff;
      endcase
      mag = acc_ff[NW-1] ? NW'(-acc_ff) : acc_ff;
      if (cmd.capture) begin
         k0_in = NW'(c0);
         t1_in = NW'(c1);
         t2_in = NW'(c2);
         t3_in = NW'(c3);
      end
      if (cmd.scale) begin
         if (cmd.step == 2'd0) begin
            t1_in = NW'(t1_ff * n_s);
         end
         if (cmd.step != 2'd2) begin
            t2_in = NW'(t2_ff * n_s);
         end
         t3_in = NW'(t3_ff * n_s);
      end
      if (cmd.horner) begin
         acc_in = NW'(src * i_s) + term;
      end
      // dividend 2|num| + den, divisor 2*den aligned to the top quotient bit
      if (cmd.div_init) begin
         rem_in = (RW'(mag) << 1) + RW'(den);
         dsh_in = RW'(den) << QUOT_BITS;
         q_in   = '0;
         neg_in = acc_ff[NW-1];
      end
      if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      k0_ff  <= k0_in;
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      t3_ff  <= t3_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   // sign and saturation of the rounded quotient
   always_comb begin
      mag12 = {1'b0, q_ff[QUOT_BITS-2:0]};
      if (q_ff[QUOT_BITS-1]) begin
         pix = neg_ff ? PIX_MIN : PIX_MAX;
      end else begin
         pix = neg_ff ? -mag12 : mag12;
      end
   end

endmodule

`default_nettype wire

// File: rtl/csst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module csst_datapath import csst_pkg::*; #(
   parameter int COORD_BITS = CSST_COORD_BITS,
   parameter int SEG_BITS   = 7
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire csst_cmd_type                 cmd,
   output csst_sts_type                      sts,
   input  wire logic [SEG_BITS-1:0]          n,
   input  wire logic [SEG_BITS-1:0]          i,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic                         req_end_of_curve,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid,
   output logic signed [PIX_BITS-1:0]        rsp_start_x,
   output logic signed [PIX_BITS-1:0]        rsp_start_y,
   output logic signed [PIX_BITS-1:0]        rsp_finish_x,
   output logic signed [PIX_BITS-1:0]        rsp_finish_y,
   output logic                              rsp_last_of_span,
   output logic                              rsp_knot_mark,
   output logic                              rsp_shape_error
);

   localparam int DW = 3 * SEG_BITS + 7;

   logic signed [COORD_BITS-1:0] wx_ff [3];
   logic signed [COORD_BITS-1:0] wy_ff [3];
   logic [DW-1:0]       den_ff, den_in;
   logic [PIX_BITS-1:0] pix_x, pix_y;
   logic [PIX_BITS-1:0] prev_x_ff, prev_y_ff;
   logic                valid_ff, valid_in;
   logic                load;

   // control point window
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            wx_ff[k] <= '0;
            wy_ff[k] <= '0;
         end
      end else if (cmd.capture) begin
         if (req_end_of_curve) begin
            for (int k = 0; k < 3; k++) begin
               wx_ff[k] <= '0;
               wy_ff[k] <= '0;
            end
         end else begin
            wx_ff[0] <= wx_ff[1];
            wx_ff[1] <= wx_ff[2];
            wx_ff[2] <= req_point_x;
            wy_ff[0] <= wy_ff[1];
            wy_ff[1] <= wy_ff[2];
            wy_ff[2] <= req_point_y;
         end
      end
   end

   // shared denominator 16*D*n^3
   always_comb begin
      den_in = den_ff;
      if (cmd.capture) begin
         den_in = DW'(den_base(cmd.kind));
      end else if (cmd.scale) begin
         den_in = DW'(den_ff * n);
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
   end

   csst_lane #(.COORD_BITS(COORD_BITS), .SEG_BITS(SEG_BITS)) u_lane_x (
      .clock (clock),
      .cmd   (cmd),
      .pa    (wx_ff[0]),
      .pb    (wx_ff[1]),
      .pc    (wx_ff[2]),
      .pd    (req_point_x),
      .n     (n),
      .i     (i),
      .den   (den_ff),
      .pix   (pix_x)
   );

   csst_lane #(.COORD_BITS(COORD_BITS), .SEG_BITS(SEG_BITS)) u_lane_y (
      .clock (clock),
      .cmd   (cmd),
      .pa    (wy_ff[0]),
      .pb    (wy_ff[1]),
      .pc    (wy_ff[2]),
      .pd    (req_point_y),
      .n     (n),
      .i     (i),
      .den   (den_ff),
      .pix   (pix_y)
   );

   // previous curve point
   always_ff @(posedge clock) begin
      if (cmd.keep_prev) begin
         prev_x_ff <= pix_x;
         prev_y_ff <= pix_y;
      end
   end

   // output register
   assign load         = cmd.emit || cmd.emit_error;
   assign sts.out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_start_x      <= prev_x_ff;
         rsp_start_y      <= prev_y_ff;
         rsp_finish_x     <= pix_x;
         rsp_finish_y     <= pix_y;
         rsp_last_of_span <= cmd.last_of_span;
         rsp_knot_mark    <= cmd.knot_mark;
         rsp_shape_error  <= 1'b0;
      end else if (cmd.emit_error) begin
         rsp_start_x      <= '0;
         rsp_start_y      <= '0;
         rsp_finish_x     <= '0;
         rsp_finish_y     <= '0;
         rsp_last_of_span <= 1'b0;
         rsp_knot_mark    <= 1'b0;
         rsp_shape_error  <= 1'b1;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// File: rtl/csst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module csst_ctrl import csst_pkg::*; #(
   parameter int MAX_SEGMENTS = CSST_MAX_SEGMENTS,
   parameter int SEG_BITS     = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_end_of_curve,
   output logic                     req_stall,
   input  wire logic [1:0]          curve_kind,
   input  wire logic [6:0]          segments_per_span,
   output csst_cmd_type             cmd,
   input  wire csst_sts_type        sts,
   output logic [SEG_BITS-1:0]      n,
   output logic [SEG_BITS-1:0]      i
);

   localparam int CNT_BITS = $clog2(QUOT_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QUOT_BITS - 1);

   csst_state_type      state_ff, state_in;
   logic [1:0]          step_ff, step_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SEG_BITS-1:0] i_ff, i_in, n_ff, n_in, n_eff;
   logic [1:0]          kind_ff, kind_in, seen_ff, seen_in, phase_ff, phase_in;
   logic                last_ff, last_in;
   logic                fire, shape_err;

   // segment count clamped to 1..MAX_SEGMENTS
   always_comb begin
      if (segments_per_span == 7'd0) begin
         n_eff = SEG_BITS'(1);
      end else if (32'(segments_per_span) > MAX_SEGMENTS) begin
         n_eff = SEG_BITS'(MAX_SEGMENTS);
      end else begin
         n_eff = SEG_BITS'(segments_per_span);
      end
   end

   // span start and bezier shape check on the incoming point
   always_comb begin
      if (curve_kind == KIND_BEZIER) begin
         fire = (seen_ff == 2'd3) && (phase_ff == 2'd0);
      end else begin
         fire = (seen_ff == 2'd3) && (curve_kind != 2'd3);
      end
      shape_err = (curve_kind == KIND_BEZIER) && req_end_of_curve && (phase_ff != 2'd0);
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      n_in      = n_ff;
      kind_in   = kind_ff;
      last_in   = last_ff;
      seen_in   = seen_ff;
      phase_in  = phase_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.kind  = kind_ff;
      cmd.step  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.kind  = curve_kind;
            if (req_valid) begin
               cmd.capture = 1'b1;
               kind_in     = curve_kind;
               last_in     = req_end_of_curve;
               n_in        = n_eff;
               step_in     = 2'd0;
               if (req_end_of_curve) begin
                  seen_in  = 2'd0;
                  phase_in = 2'd0;
               end else begin
                  seen_in  = (seen_ff == 2'd3) ? 2'd3 : seen_ff + 2'd1;
                  phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
               end
               if (shape_err) begin
                  state_in = ST_ERROR;
               end else if (fire) begin
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            if (step_ff == 2'd2) begin
               step_in  = 2'd0;
               i_in     = '0;
               state_in = ST_HORNER;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_HORNER: begin
            cmd.horner = 1'b1;
            if (step_ff == 2'd2) begin
               step_in  = 2'd0;
               state_in = ST_DIV_INIT;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // point at t=0 only seeds the segment start
            if (i_ff == '0) begin
               cmd.keep_prev = 1'b1;
               i_in          = i_ff + 1'b1;
               state_in      = ST_HORNER;
            end else if (sts.out_free) begin
               cmd.keep_prev    = 1'b1;
               cmd.emit         = 1'b1;
               cmd.last_of_span = (i_ff == n_ff);
               cmd.knot_mark    = (i_ff == n_ff) && (kind_ff == KIND_BSPLINE) && !last_ff;
               if (i_ff == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_HORNER;
               end
            end
         end
         ST_ERROR: begin
            if (sts.out_free) begin
               cmd.emit_error = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
         i_ff     <= '0;
         n_ff     <= SEG_BITS'(1);
         kind_ff  <= KIND_BEZIER;
         last_ff  <= 1'b0;
         seen_ff  <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         n_ff     <= n_in;
         kind_ff  <= kind_in;
         last_ff  <= last_in;
         seen_ff  <= seen_in;
         phase_ff <= phase_in;
      end
   end

   assign n = n_ff;
   assign i = i_ff;

endmodule

`default_nettype wire

// File: rtl/cubic_spline_segment_tessellator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  point_x, point_y, end_of_curve
// rsp_      out        rsp_valid/rsp_stall  start/finish x,y, last_of_span, knot_mark,
//                                           shape_error
// csr       in         psel/penable/pready  curve_kind (0x0), segments_per_span (0x4)
//
// a point that opens a span first scales the coefficients by n in three steps, then each
// curve point needs 3 horner steps, 1 divider setup and the bit-serial rounding divider,
// after which the segment is handed over; the point at t=0 only seeds the segment start.
// points that open no span are only captured; a shape error point also hands over an error result.
// reset is synchronous and clears the window, counters and the output valid.
// a stalled output holds the sequencer only at segment or error hand-over; inputs wait meanwhile.

module cubic_spline_segment_tessellator_core import csst_pkg::*; #(
   parameter int MAX_SEGMENTS = CSST_MAX_SEGMENTS,
   parameter int COORD_BITS   = CSST_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic                         req_end_of_curve,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [PIX_BITS-1:0]        rsp_start_x,
   output logic signed [PIX_BITS-1:0]        rsp_start_y,
   output logic signed [PIX_BITS-1:0]        rsp_finish_x,
   output logic signed [PIX_BITS-1:0]        rsp_finish_y,
   output logic                              rsp_last_of_span,
   output logic                              rsp_knot_mark,
   output logic                              rsp_shape_error,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [2:0]                   paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int SEG_BITS = $clog2(MAX_SEGMENTS + 1);

   logic [1:0]          kind_ff;
   logic [6:0]          seg_ff;
   logic                wr_en;
   csst_cmd_type        cmd;
   csst_sts_type        sts;
   logic [SEG_BITS-1:0] n, i;

   // configuration registers
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_RESET;
         seg_ff  <= SEG_RESET;
      end else if (wr_en) begin
         if (paddr[2] == REG_CURVE_KIND) begin
            kind_ff <= pwdata[1:0];
         end else begin
            seg_ff <= pwdata[6:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_SEGMENTS) ? {25'd0, seg_ff} : {30'd0, kind_ff};

   csst_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .SEG_BITS(SEG_BITS)) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_end_of_curve  (req_end_of_curve),
      .req_stall         (req_stall),
      .curve_kind        (kind_ff),
      .segments_per_span (seg_ff),
      .cmd               (cmd),
      .sts               (sts),
      .n                 (n),
      .i                 (i)
   );

   csst_datapath #(.COORD_BITS(COORD_BITS), .SEG_BITS(SEG_BITS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .n                (n),
      .i                (i),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_end_of_curve (req_end_of_curve),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_finish_x     (rsp_finish_x),
      .rsp_finish_y     (rsp_finish_y),
      .rsp_last_of_span (rsp_last_of_span),
      .rsp_knot_mark    (rsp_knot_mark),
      .rsp_shape_error  (rsp_shape_error)
   );

endmodule

`default_nettype wire

// File: rtl/csst_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module csst_checker import csst_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [PIX_BITS-1:0] rsp_start_x,
   input wire logic [PIX_BITS-1:0] rsp_start_y,
   input wire logic [PIX_BITS-1:0] rsp_finish_x,
   input wire logic [PIX_BITS-1:0] rsp_finish_y,
   input wire logic                rsp_last_of_span,
   input wire logic                rsp_knot_mark,
   input wire logic                rsp_shape_error
);

   // no item right after reset
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("item shown right after reset");

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_finish_x) && $stable(rsp_finish_y)
      && $stable(rsp_shape_error) && $stable(rsp_last_of_span))
      else $error("stalled item changed");

   // error items carry no coordinates and no span flags
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shape_error |-> rsp_start_x == '0 && rsp_start_y == '0
      && rsp_finish_x == '0 && rsp_finish_y == '0 && !rsp_last_of_span && !rsp_knot_mark)
      else $error("error item with payload");

   // knot mark only on the final segment of a span
   a_knot_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_knot_mark |-> rsp_last_of_span)
      else $error("knot mark off span end");

endmodule

bind cubic_spline_segment_tessellator_core csst_checker u_csst_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_start_x      (rsp_start_x),
   .rsp_start_y      (rsp_start_y),
   .rsp_finish_x     (rsp_finish_x),
   .rsp_finish_y     (rsp_finish_y),
   .rsp_last_of_span (rsp_last_of_span),
   .rsp_knot_mark    (rsp_knot_mark),
   .rsp_shape_error  (rsp_shape_error)
);

`default_nettype wire
